// File: rtl/upd_pkg.sv
// Package for the URL percent decoder: character codes, escape phase enum,
// queue entry type and the hex digit helper. No dependencies.
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Entries between front and back end
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_t;

  // Up to three results released by one input byte; only the final one
  // can carry the end-of-string mark.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] data;
    logic            last;
  } upd_entry_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: rtl/url_percent_decoder.sv
// URL percent decoder (form-urlencoded) top level: front end, entry queue
// and back end. Uses upd_pkg, upd_front, upd_queue, upd_back.
//
// Takes one encoded byte per beat and gives the decoded bytes: "%hh" (either
// case) becomes one byte, '+' becomes a space, and a '%' that does not start
// a valid escape comes out literally, the bytes after it decoded afresh. The
// last result of a string has out_last set. A byte is accepted every cycle
// while full is low; the front end packs the up to three results it releases
// into one entry of a four-entry queue, and the back end sends one result
// per cycle while pop is high. Sustained rate is one byte per cycle while
// each byte releases at most one result and pop stays high; a byte that
// releases more results sends them one after another, so the queue can fill.
// The front end decodes combinationally and the queue registers each entry.
`timescale 1ns / 1ps

module url_percent_decoder import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       accept;
  logic       q_push;
  logic       q_pop;
  logic       q_empty;
  upd_entry_t wr_entry;
  upd_entry_t head;

  assign accept = push && !full;

  upd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_push  (q_push),
    .q_entry (wr_entry)
  );

  upd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (head),
    .q_empty  (q_empty),
    .q_full   (full)
  );

  upd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .q_pop    (q_pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// File: rtl/upd_front.sv
// Front end of the URL percent decoder: tracks the escape phase and turns
// each input byte into one queue entry of up to three results. Uses upd_pkg.
`timescale 1ns / 1ps

module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       q_push,
  output upd_entry_t q_entry
);

  upd_phase_t phase, phase_next;
  logic [7:0] held_digit, held_digit_next;

  logic [4:0] hv;
  logic [4:0] hv_held;
  logic [1:0] pre_cnt;
  logic       tail_emit;
  logic [7:0] tail_byte;
  upd_phase_t fresh_phase;
  logic       fresh_emit;
  logic [7:0] fresh_byte;

  assign hv      = hex_value(in_byte);
  assign hv_held = hex_value(held_digit);

  // Decode the byte with no escape pending
  always_comb begin
    fresh_phase = PH_IDLE;
    fresh_emit  = 1'b1;
    fresh_byte  = in_byte;
    if (in_byte == CH_PERCENT) begin
      if (!in_last) begin
        fresh_phase = PH_PCT;
        fresh_emit  = 1'b0;
      end
    end else if (in_byte == CH_PLUS) begin
      fresh_byte = CH_SPACE;
    end
  end

  // Classify against the pending escape
  always_comb begin
    pre_cnt         = 2'd0;
    tail_emit       = fresh_emit;
    tail_byte       = fresh_byte;
    phase_next      = fresh_phase;
    held_digit_next = held_digit;
    case (phase)
      PH_PCT: begin
        if (hv[4] && !in_last) begin
          tail_emit       = 1'b0;
          phase_next      = PH_DIGIT;
          held_digit_next = in_byte;
        end else begin
          pre_cnt = 2'd1;
        end
      end
      PH_DIGIT: begin
        if (hv[4]) begin
          tail_emit  = 1'b1;
          tail_byte  = {hv_held[3:0], hv[3:0]};
          phase_next = PH_IDLE;
        end else begin
          pre_cnt = 2'd2;
        end
      end
      default: begin
      end
    endcase
  end

  // Pack the results into one entry
  always_comb begin
    q_entry.count   = pre_cnt + {1'b0, tail_emit};
    q_entry.last    = in_last;
    q_entry.data[0] = (pre_cnt != 2'd0) ? CH_PERCENT : tail_byte;
    q_entry.data[1] = (pre_cnt == 2'd2) ? held_digit : tail_byte;
    q_entry.data[2] = tail_byte;
  end

  assign q_push = accept && (q_entry.count != 2'd0);

  // Advance the escape state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'd0;
    end else if (accept) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

// File: rtl/upd_queue.sv
// Short entry queue between front and back end of the URL percent decoder.
// Uses upd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module upd_queue import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  upd_entry_t wr_entry,
  input  logic       pop,
  output upd_entry_t rd_entry,
  output logic       q_empty,
  output logic       q_full
);

  upd_entry_t           slots [QDepth];
  logic [QPtrW-1:0]     wr_ptr;
  logic [QPtrW-1:0]     rd_ptr;
  logic [QPtrW:0]       fill;

  assign q_empty  = (fill == '0);
  assign q_full   = (fill == (QPtrW+1)'(QDepth));
  assign rd_entry = slots[rd_ptr];

  // Store a pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/upd_back.sv
// Back end of the URL percent decoder: walks the results of the head entry
// one per beat and retires the entry after its final result. Uses upd_pkg.
`timescale 1ns / 1ps

module upd_back import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  upd_entry_t head,
  input  logic       q_empty,
  input  logic       pop,
  output logic       q_pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [1:0] idx;
  logic       final_slot;

  assign final_slot = ((idx + 2'd1) == head.count);
  assign empty      = q_empty;
  assign out_byte   = head.data[idx];
  assign out_last   = head.last && final_slot;
  assign q_pop      = pop && !q_empty && final_slot;

  // Step through the head entry, wrap on retire
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && !q_empty) begin
      idx <= final_slot ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// File: rtl/upd_checker.sv
// Port-level checks for the URL percent decoder, attached by bind.
// Depends only on the url_percent_decoder ports.
`timescale 1ns / 1ps

module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Reset drains the output side
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results visible after reset");

  // Results appear only after an accepted byte
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (empty && !(push && !full)) |=> empty)
    else $error("result appeared without an accepted byte");

  // A full queue holds results
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("full while no result waiting");

  // Full rises only by an accepted byte
  a_full_by_push: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("full rose without a push");

  // A waiting result holds until taken
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
    else $error("waiting result changed");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk      (clk),
  .rst      (rst),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .out_last (out_last)
);

// File: tb/sv/upd_check_pkg.sv
// Scoreboard for the URL percent decoder bench: predicts the decoded bytes of
// each accepted input beat and checks result beats in order. Uses upd_pkg.
`timescale 1ns / 1ps

package upd_check_pkg;
  import upd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } dec_beat_t;

  class decoded_byte_checker;
    upd_phase_t  esc_phase;
    logic [7:0]  first_digit;
    dec_beat_t   decoded_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      esc_phase   = PH_IDLE;
      first_digit = 8'h00;
      mismatches  = 0;
      checked     = 0;
    endfunction

    // {is hex digit, nibble value}
    function logic [4:0] nibble_of(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) begin
        return {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
        return {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
        return {1'b1, 4'(b - 8'h37)};
      end
      return 5'd0;
    endfunction

    function void add_decoded(logic [7:0] data, logic last);
      dec_beat_t beat;
      beat.data = data;
      beat.last = last;
      decoded_q.push_back(beat);
    endfunction

    // Decode a byte with no escape pending
    function void decode_plain(logic [7:0] b, logic last);
      if (b == CH_PERCENT) begin
        if (last) begin
          add_decoded(CH_PERCENT, 1'b1);
          esc_phase = PH_IDLE;
        end else begin
          esc_phase = PH_PCT;
        end
      end else if (b == CH_PLUS) begin
        add_decoded(CH_SPACE, last);
        esc_phase = PH_IDLE;
      end else begin
        add_decoded(b, last);
        esc_phase = PH_IDLE;
      end
    endfunction

    // Note one accepted input beat and queue the bytes it releases
    function void note_byte(logic [7:0] b, logic last);
      logic [4:0] nib;
      logic [4:0] hi;
      nib = nibble_of(b);
      hi  = nibble_of(first_digit);
      case (esc_phase)
        PH_PCT: begin
          if (nib[4] && !last) begin
            first_digit = b;
            esc_phase   = PH_DIGIT;
          end else begin
            add_decoded(CH_PERCENT, 1'b0);
            decode_plain(b, last);
          end
        end
        PH_DIGIT: begin
          if (nib[4]) begin
            add_decoded({hi[3:0], nib[3:0]}, last);
            esc_phase = PH_IDLE;
          end else begin
            // broken escape: release '%' and the held digit as they came
            add_decoded(CH_PERCENT, 1'b0);
            add_decoded(first_digit, 1'b0);
            decode_plain(b, last);
          end
        end
        default: decode_plain(b, last);
      endcase
    endfunction

    // Compare one result beat with the oldest predicted byte
    function void check_decoded(logic [7:0] data, logic last);
      dec_beat_t want;
      checked++;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: out_byte=%h out_last=%b", data, last);
        end
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== data || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d: expected out_byte=%h out_last=%b, got out_byte=%h out_last=%b",
                   checked, want.data, want.last, data, last);
        end
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

endpackage

// File: tb/sv/tb_url_percent_decoder.sv
// Top of the URL percent decoder bench: directed and random encoded strings
// with random stalls on both sides. Uses upd_pkg, upd_check_pkg and the RTL.
`timescale 1ns / 1ps

module tb_url_percent_decoder;
  import upd_pkg::*;
  import upd_check_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandItems  = 380;
  localparam int unsigned QuietFrom  = 300;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       push     = 1'b0;
  logic [7:0] in_byte  = 8'h00;
  logic       in_last  = 1'b0;
  logic       pop      = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;

  decoded_byte_checker sb = new();

  logic [7:0]  text_q[$];
  bit          idle_on = 1'b1;
  int unsigned items_sent;
  int unsigned strings_sent;
  int unsigned cycle_count;

  url_percent_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .empty   (empty),
    .pop     (pop),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
             sb.pending());
    $display("Mismatches found");
    $finish;
  end

  // Observe accepted beats on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note_byte(in_byte, in_last);
      end
      if (pop && !empty) begin
        sb.check_decoded(out_byte, out_last);
      end
    end
  end

  // Drain results, stalling in short bursts while idling is on
  initial begin
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Offer one beat and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic l);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Send text_q as one string, last flag on its final byte; noise scatters
  // stray last flags and drops some real ones
  task automatic send_text(input bit noisy);
    logic l;
    for (int i = 0; i < text_q.size(); i++) begin
      l = (i == text_q.size() - 1);
      if (noisy && $urandom_range(0, 5) == 0) begin
        l = 1'($urandom_range(0, 1));
      end
      send_item(text_q[i], l);
    end
    text_q.delete();
    strings_sent++;
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) begin
      return 8'(8'h30 + v);
    end
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  // Append one random token: plain byte, plus, escape or broken escape
  task automatic add_token();
    case ($urandom_range(0, 9))
      0, 1, 2: text_q.push_back(8'($urandom_range(0, 255)));
      3: text_q.push_back(CH_PLUS);
      4, 5, 6: begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(hex_char());
        text_q.push_back(hex_char());
      end
      7: begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(hex_char());
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      default: text_q.push_back(CH_PERCENT);
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings: byte extremes, escapes in both cases, plus, and
    // every way an escape can break
    text_q = '{8'h00};                          send_text(1'b0);
    text_q = '{8'hFF};                          send_text(1'b0);
    text_q = '{CH_PERCENT, 8'h34, 8'h41};       send_text(1'b0);
    text_q = '{CH_PERCENT, 8'h66, 8'h66};       send_text(1'b0);
    text_q = '{CH_PLUS};                        send_text(1'b0);
    text_q = '{CH_PERCENT, 8'h32, 8'h42};       send_text(1'b0);
    text_q = '{CH_PERCENT};                     send_text(1'b0);
    text_q = '{CH_PERCENT, 8'h34};              send_text(1'b0);
    text_q = '{CH_PERCENT, CH_PLUS};            send_text(1'b0);
    text_q = '{CH_PERCENT, CH_PERCENT};         send_text(1'b0);
    text_q = '{CH_PERCENT, 8'h34, CH_PERCENT};  send_text(1'b0);
    text_q = '{CH_PERCENT, 8'h34, 8'h47};       send_text(1'b0);

    // Random strings, mostly well formed; the tail runs without idling
    while (items_sent < RandItems) begin
      idle_on = (items_sent < QuietFrom) && ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 5)) add_token();
      send_text($urandom_range(0, 9) == 0);
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("sent %0d encoded bytes in %0d strings, checked %0d decoded bytes",
             items_sent, strings_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats", sb.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
